[hdl/wsl_pkg.sv]
// ----------------------------------------------------------------------------
// wsl_pkg
// Shared types and constants for the section locator.
// ----------------------------------------------------------------------------
`default_nettype none

package wsl_pkg;

  // bytes of the module header skipped without checks
  localparam int unsigned HEADER_BYTES = 8;
  // width of the byte position counter and the reported offset
  localparam int unsigned OFFSET_BITS = 32;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  // reset value of the target section id (code section)
  localparam logic [7:0] TARGET_RESET = 8'd10;

  // LEB128 byte fields
  localparam logic [7:0] LEB_DATA_MASK = 8'h7F;
  localparam int unsigned LEB_DIGIT_BITS = 7;
  localparam logic [5:0] SHIFT_MAX = 6'd63;

  // result status codes
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ID     = 3'd1,
    PH_SIZE   = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [OFFSET_BITS-1:0] payload_offset;
  } result_t;

endpackage

`default_nettype wire

[hdl/wsl_in_stage.sv]
// ----------------------------------------------------------------------------
// wsl_in_stage
// Input register: holds one request until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsl_in_stage
  import wsl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire item_t in_item,
  output logic       item_valid,
  output item_t      item,
  input  wire logic  take
);

  logic load;

  // full and not drained this cycle: stall the sender
  assign in_stall = item_valid && !take;
  assign load     = in_valid && !in_stall;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

[hdl/wsl_core.sv]
// ----------------------------------------------------------------------------
// wsl_core
// Section walker: header skip, id, LEB128 size, payload skip, a byte a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module wsl_core
  import wsl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       item_valid,
  input  wire item_t      item,
  output logic            take,
  input  wire logic       res_free,
  output logic            res_push,
  output result_t         res
);

  logic [7:0]             target_id;
  logic [OFFSET_BITS-1:0] byte_position;
  phase_t                 parse_phase;
  logic [7:0]             current_id;
  logic [31:0]            size_acc;
  logic [5:0]             size_shift;
  logic [31:0]            bytes_to_skip;

  logic [OFFSET_BITS-1:0] pos_cur;
  phase_t                 phase_cur;
  logic [7:0]             id_cur;
  logic [31:0]            acc_cur;
  logic [5:0]             shift_cur;
  logic [31:0]            skip_cur;

  logic [OFFSET_BITS-1:0] pos_inc;
  logic [31:0]            acc_digit;
  logic [31:0]            skip_dec;

  logic [OFFSET_BITS-1:0] byte_position_next;
  phase_t                 parse_phase_next;
  logic [7:0]             current_id_next;
  logic [31:0]            size_acc_next;
  logic [5:0]             size_shift_next;
  logic [31:0]            bytes_to_skip_next;

  logic has_result;

  // target register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_id <= TARGET_RESET;
    end else if (cfg_we) begin
      target_id <= cfg_wdata;
    end
  end

  // first byte of a binary restarts all parse state
  always_comb begin
    if (item.first_byte) begin
      pos_cur   = '0;
      phase_cur = PH_HEADER;
      id_cur    = '0;
      acc_cur   = '0;
      shift_cur = '0;
      skip_cur  = '0;
    end else begin
      pos_cur   = byte_position;
      phase_cur = parse_phase;
      id_cur    = current_id;
      acc_cur   = size_acc;
      shift_cur = size_shift;
      skip_cur  = bytes_to_skip;
    end
    if (phase_cur == PH_HEADER && pos_cur >= OFFSET_BITS'(HEADER_BYTES)) begin
      phase_cur = PH_ID;
    end
  end

  // saturating position, LEB128 digit placement, skip countdown
  assign pos_inc   = (pos_cur == POS_MAX) ? pos_cur : pos_cur + OFFSET_BITS'(1);
  assign acc_digit = shift_cur[5] ? 32'd0
                   : ({24'd0, item.data_byte & LEB_DATA_MASK} << shift_cur[4:0]);
  assign skip_dec  = skip_cur - 32'd1;

  // next state and result
  always_comb begin
    byte_position_next = pos_inc;
    parse_phase_next   = phase_cur;
    current_id_next    = id_cur;
    size_acc_next      = acc_cur;
    size_shift_next    = shift_cur;
    bytes_to_skip_next = skip_cur;
    has_result         = 1'b0;
    res.status         = ST_FOUND;
    res.payload_offset = '0;
    case (phase_cur)
      PH_HEADER: begin
      end
      PH_ID: begin
        current_id_next  = item.data_byte;
        size_acc_next    = '0;
        size_shift_next  = '0;
        parse_phase_next = PH_SIZE;
      end
      PH_SIZE: begin
        size_acc_next = acc_cur | acc_digit;
        if (item.data_byte[7]) begin
          size_shift_next = (shift_cur > SHIFT_MAX - 6'(LEB_DIGIT_BITS)) ? SHIFT_MAX
                          : shift_cur + 6'(LEB_DIGIT_BITS);
        end else if (id_cur == target_id) begin
          has_result         = 1'b1;
          res.status         = ST_FOUND;
          res.payload_offset = pos_inc;
          parse_phase_next   = PH_DONE;
        end else begin
          bytes_to_skip_next = acc_cur | acc_digit;
          parse_phase_next   = ((acc_cur | acc_digit) == 32'd0) ? PH_ID : PH_SKIP;
        end
      end
      PH_SKIP: begin
        bytes_to_skip_next = skip_dec;
        if (skip_dec == 32'd0) begin
          parse_phase_next = PH_ID;
        end
      end
      default: begin
        parse_phase_next = PH_DONE;
      end
    endcase
    // end of binary without a find
    if (!has_result && item.last_byte && parse_phase_next != PH_DONE) begin
      has_result       = 1'b1;
      res.status       = (parse_phase_next == PH_SIZE) ? ST_TRUNCATED : ST_NOT_FOUND;
      parse_phase_next = PH_DONE;
    end
  end

  // a byte with a result waits for room in the output register
  assign take     = item_valid && (!has_result || res_free);
  assign res_push = take && has_result;

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      parse_phase   <= PH_HEADER;
      current_id    <= '0;
      size_acc      <= '0;
      size_shift    <= '0;
      bytes_to_skip <= '0;
    end else if (take) begin
      byte_position <= byte_position_next;
      parse_phase   <= parse_phase_next;
      current_id    <= current_id_next;
      size_acc      <= size_acc_next;
      size_shift    <= size_shift_next;
      bytes_to_skip <= bytes_to_skip_next;
    end
  end

endmodule

`default_nettype wire

[hdl/wsl_out_stage.sv]
// ----------------------------------------------------------------------------
// wsl_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsl_out_stage
  import wsl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_push,
  input  wire result_t res,
  output logic         res_free,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_res
);

  // empty, or being drained this cycle
  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

[hdl/wasm_section_locator_unit.sv]
// ----------------------------------------------------------------------------
// wasm_section_locator_unit
// Finds the payload start offset of a chosen section in a WebAssembly binary.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, back to back, with no gaps needed between bytes
// or binaries. Each byte goes through an input register and the parse logic,
// and a result it causes is loaded into the result register; a byte that
// produces a result waits only if the result register is still full.
// Status 0 reports the payload offset of the first section whose id matches
// the target id; status 1 means the binary ended without it, status 2 that
// it ended after a section id, before or inside its size field. After a
// result, bytes are ignored until first_byte marks a new binary. Write the
// target id only while the block is idle.
`default_nettype none

module wasm_section_locator_unit
  import wsl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [7:0]             cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   first_byte,
  input  wire logic                   last_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  status,
  output logic [OFFSET_BITS-1:0]      payload_offset
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    res_free;
  logic    res_push;
  result_t res;
  result_t out_res;

  assign in_item.data_byte  = data_byte;
  assign in_item.first_byte = first_byte;
  assign in_item.last_byte  = last_byte;

  wsl_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  wsl_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .res_free   (res_free),
    .res_push   (res_push),
    .res        (res)
  );

  wsl_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .res_push   (res_push),
    .res        (res),
    .res_free   (res_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign status         = out_res.status;
  assign payload_offset = out_res.payload_offset;

`ifndef NO_ASSERTIONS
  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_FOUND || status == ST_NOT_FOUND || status == ST_TRUNCATED))
    else $error("undefined status code");

  // offset is zero unless the section was found
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_FOUND) |-> (payload_offset == '0))
    else $error("nonzero offset on a not-found result");

  // a found payload lies past the header, an id and a size byte
  a_offset_min: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FOUND)
      |-> (payload_offset >= OFFSET_BITS'(HEADER_BYTES + 2)))
    else $error("found offset inside the header");

  // a result is only pushed when the result register has room
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_free)
    else $error("result pushed into a full register");
`endif

endmodule

`default_nettype wire
